// File: design/aes128_cipher_with_block_modes_unit_macros.svh
// assertion macros shared by the aes block-mode engine
`ifndef AES128_CIPHER_WITH_BLOCK_MODES_UNIT_MACROS_SVH
`define AES128_CIPHER_WITH_BLOCK_MODES_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AESBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define AESBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/aesbm_pkg.sv
// shared types, constants and byte functions for the aes block-mode engine
`timescale 1ns / 1ps
package aesbm_pkg;

  localparam int NUM_ROUND_KEYS_DEF = 11;
  localparam int RK_AW = $clog2(NUM_ROUND_KEYS_DEF);
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_MODE     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_ECB_ENC = 3'd0,
    MODE_ECB_DEC = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CTR     = 3'd4
  } mode_t;

  // round key write port from the expansion sequencer
  typedef struct packed {
    logic             en;
    logic [RK_AW-1:0] addr;
    logic [127:0]     data;
  } kx_wr_t;

  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX_BITS = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX_BITS[2047 - 8 * int'(b) -: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    return INV_SBOX_BITS[2047 - 8 * int'(b) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one column of mix columns, byte 0 in the top bits
  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] res;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31 - 8 * k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m1[k] = a[k];
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        res[31 - 8 * r -: 8] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
      end else begin
        res[31 - 8 * r -: 8] = m2[r] ^ m3[(r + 1) % 4] ^ m1[(r + 2) % 4] ^ m1[(r + 3) % 4];
      end
    end
    return res;
  endfunction

endpackage

// File: design/aesbm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module aesbm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/aesbm_keyexp.sv
// key expansion sequencer, one round key row per cycle
`timescale 1ns / 1ps
module aesbm_keyexp #(
  parameter int NUM_ROUND_KEYS = aesbm_pkg::NUM_ROUND_KEYS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [127:0]     key,
  output logic             busy,
  output aesbm_pkg::kx_wr_t kx_wr
);
  import aesbm_pkg::*;

  localparam logic [RK_AW-1:0] LAST_ROW = RK_AW'(NUM_ROUND_KEYS - 1);

  logic             busy_r;
  logic [RK_AW-1:0] row_idx_r;
  logic [127:0]     row_r;
  logic [7:0]       rcon_r;
  logic [127:0]     row_nxt;
  logic [31:0]      w0;
  logic [31:0]      w1;
  logic [31:0]      w2;
  logic [31:0]      w3;
  logic [31:0]      rot;

  // next row from the current one
  always_comb begin
    rot = {row_r[23:0], row_r[31:24]};
    w0  = row_r[127:96] ^ {sbox(rot[31:24]), sbox(rot[23:16]), sbox(rot[15:8]),
                           sbox(rot[7:0])} ^ {rcon_r, 24'h0};
    w1  = row_r[95:64] ^ w0;
    w2  = row_r[63:32] ^ w1;
    w3  = row_r[31:0] ^ w2;
    row_nxt = {w0, w1, w2, w3};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      row_idx_r <= '0;
      rcon_r    <= 8'h01;
    end else if (start) begin
      busy_r    <= 1'b1;
      row_idx_r <= '0;
      rcon_r    <= 8'h01;
      row_r     <= key;
    end else if (busy_r) begin
      if (row_idx_r == LAST_ROW) begin
        busy_r <= 1'b0;
      end else begin
        row_idx_r <= row_idx_r + 1'b1;
        row_r     <= row_nxt;
        rcon_r    <= xtime(rcon_r);
      end
    end
  end

  assign busy       = busy_r;
  assign kx_wr.en   = busy_r && !start;
  assign kx_wr.addr = row_idx_r;
  assign kx_wr.data = row_r;

endmodule

// File: design/aesbm_round.sv
// one aes round, encrypt or decrypt, shared by all rounds
`timescale 1ns / 1ps
module aesbm_round (
  input  logic [127:0] state_in,
  input  logic [127:0] rnd_key,
  input  logic         dec,
  input  logic         last,
  output logic [127:0] state_out
);
  import aesbm_pkg::*;

  logic [7:0]   b [16];
  logic [7:0]   t [16];
  logic [127:0] flat;
  logic [127:0] keyed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = state_in[127 - 8 * i -: 8];
    end
    // substitution and row shift
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          t[r + 4 * ((c + r) % 4)] = inv_sbox(b[r + 4 * c]);
        end else begin
          t[r + 4 * c] = sbox(b[r + 4 * ((c + r) % 4)]);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      flat[127 - 8 * i -: 8] = t[i];
    end
    // encrypt mixes before the key, decrypt after
    keyed = flat;
    if (!dec && !last) begin
      for (int c = 0; c < 4; c++) begin
        keyed[127 - 32 * c -: 32] = mix_col(flat[127 - 32 * c -: 32], 1'b0);
      end
    end
    keyed = keyed ^ rnd_key;
    state_out = keyed;
    if (dec && !last) begin
      for (int c = 0; c < 4; c++) begin
        state_out[127 - 32 * c -: 32] = mix_col(keyed[127 - 32 * c -: 32], 1'b1);
      end
    end
  end

endmodule

// File: design/aes128_cipher_with_block_modes_unit.sv
// AES-128 engine with ECB, CBC and CTR modes: one 128-bit block per
// transaction, processed one round per cycle by a single shared round unit.
// An accepted block passes through S_LOAD for the initial key addition,
// ten rounds in S_ROUND and S_DONE, which applies the mode's output XOR
// into the output register; the first round key is fetched as the block is
// accepted. The input is ready again once the sequencer is back in S_IDLE,
// so a new block is taken only after the previous one is through, later if
// the previous result is still waiting in the output register.
// After reset, and after each key register write, the key schedule is
// rebuilt one round key per cycle; the input is not ready meanwhile.
`timescale 1ns / 1ps
`include "aes128_cipher_with_block_modes_unit_macros.svh"
module aes128_cipher_with_block_modes_unit #(
  parameter int NUM_ROUND_KEYS = aesbm_pkg::NUM_ROUND_KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aesbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    in_block_high,
  input  logic [63:0]                    in_block_low,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    out_result_high,
  output logic [63:0]                    out_result_low
);
  import aesbm_pkg::*;

  localparam logic [RK_AW-1:0] LAST_RK = RK_AW'(NUM_ROUND_KEYS - 1);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_DONE} fsm_t;

  fsm_t             state_r;
  logic [63:0]      key_high_r;
  logic [63:0]      key_low_r;
  logic [63:0]      iv_high_r;
  logic [63:0]      iv_low_r;
  logic [2:0]       mode_r;
  logic [127:0]     chain_r;
  logic [127:0]     st_r;
  logic [127:0]     px_r;
  logic             dec_r;
  logic             cbc_enc_r;
  logic [RK_AW-1:0] addr_r;
  logic [RK_AW-1:0] addr_nxt;
  logic [RK_AW-1:0] cnt_r;
  logic             out_valid_r;
  logic [127:0]     out_r;
  logic             start_r;
  logic             key_wr;
  logic             cfg_wr;
  logic             in_acc;
  logic             kx_busy;
  kx_wr_t           kx_wr;
  logic [127:0]     rk;
  logic [127:0]     rnd_out;
  logic [127:0]     blk;
  logic [127:0]     chn;
  logic             last_rnd;
  logic             mode_dec;
  logic [127:0]     st_ld;
  logic [127:0]     px_ld;
  logic [127:0]     chain_ld;
  logic             cbc_ld;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_wr    = cfg_wr && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  assign in_ready  = (state_r == S_IDLE) && !kx_busy && !start_r;
  assign in_acc    = in_valid && in_ready;
  assign blk       = {in_block_high, in_block_low};
  assign chn       = in_restart ? {iv_high_r, iv_low_r} : chain_r;
  assign last_rnd  = (cnt_r == LAST_RK);
  assign mode_dec  = (mode_r == MODE_ECB_DEC) || (mode_r == MODE_CBC_DEC);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // configuration registers, expansion starts once the new key is in place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
      mode_r     <= MODE_ECB_ENC;
      start_r    <= 1'b1;
    end else begin
      start_r <= key_wr;
      if (cfg_wr) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_KEY_HIGH: key_high_r <= cfg_data;
          REG_KEY_LOW:  key_low_r  <= cfg_data;
          REG_IV_HIGH:  iv_high_r  <= cfg_data;
          REG_IV_LOW:   iv_low_r   <= cfg_data;
          REG_MODE:     mode_r     <= cfg_data[2:0];
          default:      ;
        endcase
      end
    end
  end

  aesbm_keyexp #(.NUM_ROUND_KEYS(NUM_ROUND_KEYS)) u_keyexp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .key   ({key_high_r, key_low_r}),
    .busy  (kx_busy),
    .kx_wr (kx_wr)
  );

  // round key read address, data lines up with addr_r
  always_comb begin
    addr_nxt = addr_r;
    unique case (state_r)
      S_IDLE:  addr_nxt = mode_dec ? LAST_RK : '0;
      S_LOAD,
      S_ROUND: if (!(state_r == S_ROUND && last_rnd)) begin
        addr_nxt = dec_r ? addr_r - 1'b1 : addr_r + 1'b1;
      end
      S_DONE:  addr_nxt = addr_r;
      default: addr_nxt = addr_r;
    endcase
  end

  // values loaded when a block is accepted, per mode
  always_comb begin
    st_ld    = blk;
    px_ld    = '0;
    chain_ld = chn;
    cbc_ld   = 1'b0;
    unique case (mode_t'(mode_r))
      MODE_CBC_ENC: begin
        st_ld  = blk ^ chn;
        cbc_ld = 1'b1;
      end
      MODE_CBC_DEC: begin
        px_ld    = chn;
        chain_ld = blk;
      end
      MODE_CTR: begin
        st_ld    = chn;
        px_ld    = blk;
        chain_ld = chn + 128'd1;
      end
      default: ;
    endcase
  end

  aesbm_ram #(.WIDTH(128), .DEPTH(NUM_ROUND_KEYS)) u_rk_ram (
    .clk     (clk),
    .wr_en   (kx_wr.en),
    .wr_addr (kx_wr.addr),
    .wr_data (kx_wr.data),
    .rd_addr (addr_nxt),
    .rd_data (rk)
  );

  aesbm_round u_round (
    .state_in  (st_r),
    .rnd_key   (rk),
    .dec       (dec_r),
    .last      (last_rnd),
    .state_out (rnd_out)
  );

  // block sequencer, chaining value and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      cnt_r       <= '0;
      dec_r       <= 1'b0;
      cbc_enc_r   <= 1'b0;
    end else begin
      addr_r      <= addr_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          state_r   <= S_LOAD;
          dec_r     <= mode_dec;
          cbc_enc_r <= cbc_ld;
          px_r      <= px_ld;
          st_r      <= st_ld;
          chain_r   <= chain_ld;
        end
        S_LOAD: begin
          st_r    <= st_r ^ rk;
          cnt_r   <= RK_AW'(1);
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          st_r <= rnd_out;
          if (last_rnd) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: if (out_load) begin
          out_r <= st_r ^ px_r;
          if (cbc_enc_r) begin
            chain_r <= st_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = out_r[127:64];
  assign out_result_low  = out_r[63:0];

  // checks that no block runs while the key schedule is being rebuilt
  `AESBM_ASSERT_NOW(a_no_cipher_in_expand, kx_busy, state_r == S_IDLE, "block in flight during key expansion")
  // an accepted block starts with the key addition
  `AESBM_ASSERT_NEXT(a_accept_loads, in_acc, state_r == S_LOAD, "accepted block did not start")
  // the last round always hands over to the output stage
  `AESBM_ASSERT_NEXT(a_last_round_done, state_r == S_ROUND && last_rnd, state_r == S_DONE, "round count overrun")

endmodule
